// ===== rtl/assert_macros.svh =====
// Assertion macros for the trimmed peak-to-peak block.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpp_pkg.sv =====
// Package for the trimmed peak-to-peak block: payload and control types, constants.
// No dependencies.
`default_nettype none

package tpp_pkg;

  localparam int unsigned SampleFieldBits = 12;
  localparam int unsigned SpreadBits      = 20;
  localparam int unsigned FracBits        = 8;
  localparam logic [SpreadBits-1:0] SpreadMax = '1;

  typedef struct packed {
    logic [SampleFieldBits-1:0] sample;
    logic                       last_sample;
  } tpp_in_t;

  typedef struct packed {
    logic [SpreadBits-1:0] spread_q8;
    logic                  too_short;
  } tpp_out_t;

  typedef struct packed {
    logic advance;
    logic flush;
  } tpp_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tpp_cell.sv =====
// One cell of the insertion chain: holds one entry of the low list and one of the high list.
// Depends on tpp_pkg.
`default_nettype none

module tpp_cell
  import tpp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tpp_ctrl_t              ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [SAMPLE_BITS-1:0] prev_lo_i,
  input  wire logic [SAMPLE_BITS-1:0] prev_hi_i,
  output logic      [SAMPLE_BITS-1:0] lo_o,
  output logic      [SAMPLE_BITS-1:0] hi_o
);

  logic [SAMPLE_BITS-1:0] lo_q, lo_d;
  logic [SAMPLE_BITS-1:0] hi_q, hi_d;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.advance) begin
      if (ctrl_i.flush) begin
        lo_d = '1;
        hi_d = '0;
      end else begin
        if (sample_i < lo_q) begin
          lo_d = (prev_lo_i > sample_i) ? prev_lo_i : sample_i;
        end
        if (sample_i > hi_q) begin
          hi_d = (prev_hi_i < sample_i) ? prev_hi_i : sample_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '1;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

`default_nettype wire

// ===== rtl/tpp_div.sv =====
// Scale-and-divide pipeline: (diff * 256) / EXTREMES by reciprocal multiply and one correction.
// Two register stages with valid/ready; depends on tpp_pkg.
`default_nettype none

module tpp_div
  import tpp_pkg::*;
#(
  parameter int unsigned SUM_BITS = 15,
  parameter int unsigned EXTREMES = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SUM_BITS-1:0] diff_i,
  input  wire logic                short_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tpp_out_t                 out_data_o
);

  localparam int unsigned XW = SUM_BITS + FracBits;
  localparam int unsigned S  = XW;
  localparam int unsigned PW = SUM_BITS + S + 1;
  localparam longint unsigned RecipL = (64'd1 << S) / EXTREMES;
  localparam logic [S:0] Recip = RecipL[S:0];

  logic [PW-1:0] prod;
  logic [XW-1:0] q_est;

  logic          s2_v_q;
  logic [XW-1:0] s2_q_q;
  logic [SUM_BITS-1:0] s2_diff_q;
  logic          s2_short_q;
  logic          s2_rdy, out_rdy;

  logic          out_v_q;
  tpp_out_t      out_q, out_d;

  logic [XW-1:0] x_full;
  logic [XW-1:0] qe;
  logic [XW-1:0] rem;
  logic [XW:0]   q_fix;
  logic [31:0]   q_ext;

  assign prod  = PW'(diff_i) * PW'(Recip);
  assign q_est = prod[SUM_BITS +: XW];

  assign out_rdy    = !out_v_q || out_ready_i;
  assign s2_rdy     = !s2_v_q || out_rdy;
  assign in_ready_o = s2_rdy;

  always_comb begin
    x_full = {s2_diff_q, {FracBits{1'b0}}};
    qe     = XW'(s2_q_q * XW'(EXTREMES));
    rem    = x_full - qe;
    q_fix  = {1'b0, s2_q_q} + ((rem >= XW'(EXTREMES)) ? (XW + 1)'(1) : '0);
    q_ext  = 32'(q_fix);
    out_d.too_short = s2_short_q;
    if (s2_short_q) begin
      out_d.spread_q8 = '0;
    end else if (q_ext > 32'(SpreadMax)) begin
      out_d.spread_q8 = SpreadMax;
    end else begin
      out_d.spread_q8 = q_ext[SpreadBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_v_q <= in_valid_i;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && in_valid_i) begin
      s2_q_q     <= q_est;
      s2_diff_q  <= diff_i;
      s2_short_q <= short_i;
    end
    if (out_rdy && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/trimmed_peak_to_peak.sv =====
// Trimmed peak-to-peak: top level with the insertion chain, running sums and result pipeline.
// Depends on tpp_pkg, tpp_cell, tpp_div and assert_macros.svh.
//
// Usage:
//   Input channel in_valid_i/in_ready_o/in_data_i carries one ADC sample per
//   transaction; last_sample marks the end of a frame. Output channel
//   out_valid_o/out_ready_i/out_data_o carries one result per frame.
//   The chain of cells keeps the EXTREMES smallest and largest samples, each
//   cell updating from its neighbor in the same cycle, so one sample is taken
//   every cycle while in_ready_o is high. Running sums of both lists track
//   each insertion. The result passes three register stages (sum latch,
//   reciprocal multiply, correction and output register); out_valid_o rises
//   once the frame has passed all three. While out_ready_i stays high, frames
//   of one sample each still sustain one transaction per cycle.
//   Reset clears both lists (low entries to all ones, high entries to zero),
//   the high sum and the count, sets the low sum to EXTREMES times all ones,
//   and empties the pipeline; every last sample does the same but for
//   the pipeline. When the receiver stalls, the three result stages fill and
//   then in_ready_o drops until out_ready_i returns.
`default_nettype none

`include "assert_macros.svh"

module trimmed_peak_to_peak
  import tpp_pkg::*;
#(
  parameter int unsigned EXTREMES    = 5,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tpp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output tpp_out_t      out_data_o
);

  localparam int unsigned CW       = $clog2(EXTREMES + 1);
  localparam int unsigned SUM_BITS = SAMPLE_BITS + CW;
  localparam logic [SUM_BITS-1:0] SumLoRst =
    SUM_BITS'(EXTREMES * ((1 << SAMPLE_BITS) - 1));

  tpp_ctrl_t              ctrl;
  logic [SAMPLE_BITS-1:0] v;
  logic [SAMPLE_BITS-1:0] lo_w [EXTREMES];
  logic [SAMPLE_BITS-1:0] hi_w [EXTREMES];

  logic [SUM_BITS-1:0] sum_lo_q, sum_lo_d;
  logic [SUM_BITS-1:0] sum_hi_q, sum_hi_d;
  logic [CW-1:0]       cnt_q, cnt_d;

  logic                s1_v_q;
  logic [SUM_BITS-1:0] s1_diff_q;
  logic                s1_short_q;
  logic                s1_rdy, div_rdy;

  assign v            = SAMPLE_BITS'(in_data_i.sample);
  assign ctrl.advance = in_valid_i && in_ready_o;
  assign ctrl.flush   = ctrl.advance && in_data_i.last_sample;

  for (genvar i = 0; i < EXTREMES; i++) begin : g_cell
    tpp_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (v),
      .prev_lo_i((i == 0) ? '0 : lo_w[(i == 0) ? 0 : i - 1]),
      .prev_hi_i((i == 0) ? '1 : hi_w[(i == 0) ? 0 : i - 1]),
      .lo_o     (lo_w[i]),
      .hi_o     (hi_w[i])
    );
  end

  always_comb begin
    sum_lo_d = sum_lo_q;
    sum_hi_d = sum_hi_q;
    cnt_d    = cnt_q;
    if (v < lo_w[EXTREMES-1]) begin
      sum_lo_d = sum_lo_q - SUM_BITS'(lo_w[EXTREMES-1]) + SUM_BITS'(v);
    end
    if (v > hi_w[EXTREMES-1]) begin
      sum_hi_d = sum_hi_q - SUM_BITS'(hi_w[EXTREMES-1]) + SUM_BITS'(v);
    end
    if (cnt_q < CW'(EXTREMES)) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  assign s1_rdy     = !s1_v_q || div_rdy;
  assign in_ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_lo_q <= SumLoRst;
      sum_hi_q <= '0;
      cnt_q    <= '0;
      s1_v_q   <= 1'b0;
    end else begin
      if (ctrl.flush) begin
        sum_lo_q <= SumLoRst;
        sum_hi_q <= '0;
        cnt_q    <= '0;
      end else if (ctrl.advance) begin
        sum_lo_q <= sum_lo_d;
        sum_hi_q <= sum_hi_d;
        cnt_q    <= cnt_d;
      end
      if (s1_rdy) begin
        s1_v_q <= ctrl.flush;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.flush) begin
      s1_diff_q  <= (sum_hi_d >= sum_lo_d) ? sum_hi_d - sum_lo_d : '0;
      s1_short_q <= cnt_d < CW'(EXTREMES);
    end
  end

  tpp_div #(
    .SUM_BITS(SUM_BITS),
    .EXTREMES(EXTREMES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_v_q),
    .in_ready_o (div_rdy),
    .diff_i     (s1_diff_q),
    .short_i    (s1_short_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `TPP_ASSERT_NEXT(a_flush_clears, ctrl.flush, (sum_lo_q == SumLoRst) && (sum_hi_q == '0) && (cnt_q == '0), "state not cleared after frame end")
  `TPP_ASSERT_NOW(a_sums_ordered, cnt_q == CW'(EXTREMES), sum_hi_q >= sum_lo_q, "high sum below low sum in full frame")
  `TPP_ASSERT_NOW(a_short_zero, out_valid_o && out_data_o.too_short, out_data_o.spread_q8 == '0, "short frame with nonzero spread")
  `TPP_ASSERT_NEXT(a_s1_hold, s1_v_q && !div_rdy, s1_v_q && $stable(s1_diff_q) && $stable(s1_short_q), "pending frame sum lost under stall")

endmodule

`default_nettype wire

// ===== test/trimmed_peak_to_peak_tb.sv =====
// Testbench for trimmed_peak_to_peak: drives ADC frames and checks each frame's trimmed spread.
// Depends on tpp_pkg and the trimmed_peak_to_peak RTL.
// A scoreboard class keeps the five lowest and highest codes per frame and predicts every result.
module trimmed_peak_to_peak_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpp_pkg::*;

  localparam int unsigned Extremes   = 5;
  localparam int unsigned SampleBits = 12;
  localparam int unsigned CodeMax    = (1 << SampleBits) - 1;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  class spread_scoreboard;
    int unsigned low_keep[Extremes];
    int unsigned high_keep[Extremes];
    int unsigned frame_len;
    tpp_out_t    expected_spreads[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      for (int i = 0; i < Extremes; i++) begin
        low_keep[i]  = CodeMax;
        high_keep[i] = 0;
      end
      frame_len = 0;
    endfunction

    function void note_sample(tpp_in_t d);
      int unsigned code;
      int          p;
      longint unsigned sum_lo, sum_hi, spread;
      tpp_out_t    res;
      code = d.sample & CodeMax;
      if (code < low_keep[Extremes-1]) begin
        p = Extremes - 1;
        while (p > 0 && low_keep[p-1] > code) begin
          low_keep[p] = low_keep[p-1];
          p--;
        end
        low_keep[p] = code;
      end
      if (code > high_keep[Extremes-1]) begin
        p = Extremes - 1;
        while (p > 0 && high_keep[p-1] < code) begin
          high_keep[p] = high_keep[p-1];
          p--;
        end
        high_keep[p] = code;
      end
      if (frame_len < Extremes) frame_len++;
      if (d.last_sample) begin
        if (frame_len < Extremes) begin
          res.spread_q8 = '0;
          res.too_short = 1'b1;
        end else begin
          sum_lo = 0;
          sum_hi = 0;
          for (int i = 0; i < Extremes; i++) begin
            sum_lo += low_keep[i];
            sum_hi += high_keep[i];
          end
          spread = (sum_hi >= sum_lo) ? sum_hi - sum_lo : 0;
          spread = (spread << FracBits) / Extremes;
          if (spread > SpreadMax) spread = SpreadMax;
          res.spread_q8 = spread[SpreadBits-1:0];
          res.too_short = 1'b0;
        end
        expected_spreads.push_back(res);
        clear_frame();
      end
    endfunction

    function void check_result(tpp_out_t got);
      tpp_out_t exp;
      if (expected_spreads.size() == 0) begin
        $error("unexpected result: spread_q8 %0d too_short %0b", got.spread_q8, got.too_short);
        errors++;
        return;
      end
      exp = expected_spreads.pop_front();
      if (got.spread_q8 !== exp.spread_q8) begin
        $error("spread_q8: expected %0d, actual %0d", exp.spread_q8, got.spread_q8);
        errors++;
      end
      if (got.too_short !== exp.too_short) begin
        $error("too_short: expected %0b, actual %0b", exp.too_short, got.too_short);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_spreads.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  tpp_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tpp_out_t out_data_o;

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned holds_requested = 0;
  int unsigned sent_count      = 0;

  spread_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  trimmed_peak_to_peak DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_sample(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  task automatic send_sample(input logic [SampleFieldBits-1:0] code, input logic last);
    tpp_in_t d;
    d.sample      = code;
    d.last_sample = last;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  function automatic logic [SampleFieldBits-1:0] pick_sample(int unsigned style,
                                                            int unsigned center);
    int unsigned k;
    case (style)
      0: return SampleFieldBits'($urandom_range(0, CodeMax));
      1: return SampleFieldBits'((center + $urandom_range(0, 15)) & CodeMax);
      2: begin
        k = $urandom_range(2);
        if (k == 0) return '0;
        if (k == 1) return SampleFieldBits'(CodeMax);
        return SampleFieldBits'($urandom_range(0, CodeMax));
      end
      default: begin
        k = $urandom_range(SampleBits - 1);
        return SampleFieldBits'($urandom_range(1) ? (1 << k) : (CodeMax ^ (1 << k)));
      end
    endcase
  endfunction

  task automatic send_random_frame(input int unsigned len);
    int unsigned style;
    int unsigned center;
    style  = $urandom_range(3);
    center = $urandom_range(0, CodeMax);
    for (int unsigned i = 0; i < len; i++)
      send_sample(pick_sample(style, center), i == len - 1);
  endtask

  task automatic run_frames(input int unsigned quota, input logic short_only);
    int unsigned target;
    int unsigned pick;
    target = sent_count + quota;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (short_only)    send_random_frame($urandom_range(1, 3));
      else if (pick < 10) send_random_frame($urandom_range(1, Extremes - 1));
      else if (pick < 90) send_random_frame($urandom_range(Extremes, 40));
      else                send_random_frame($urandom_range(41, 120));
    end
  endtask

  initial begin : main
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(12'd0, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b1);
    for (int i = 0; i < 5; i++) send_sample((i % 2) ? 12'd4095 : 12'd0, i == 4);
    for (int i = 0; i < 10; i++) send_sample((i < 5) ? 12'd0 : 12'd4095, i == 9);
    for (int i = 0; i < 6; i++) send_sample(12'd2048, i == 5);

    run_frames(380, 1'b0);
    send_idle_pct  = 85;
    recv_stall_pct <= 0;
    run_frames(350, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct <= 85;
    run_frames(350, 1'b0);
    send_idle_pct  = 38;
    recv_stall_pct <= 38;
    run_frames(350, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    holds_requested <= holds_requested + 1;
    run_frames(400, 1'b1);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tpp_pkg.sv
rtl/tpp_cell.sv
rtl/tpp_div.sv
rtl/trimmed_peak_to_peak.sv
test/trimmed_peak_to_peak_tb.sv
